// ===== sv/psba_pkg.sv =====
`default_nettype none

package psba_pkg;

    // Default sizes of the bin store.
    localparam int BINS_DEF       = 4096;
    localparam int COUNT_BITS_DEF = 16;

    // Register field widths.
    localparam int COORD_W = 24;
    localparam int STEP_W  = 20;
    localparam int BCNT_W  = 13;
    localparam int SLAB_W  = 23;
    localparam int INDEX_W = 12;
    localparam int PCNT_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register reset values.
    localparam logic signed [COORD_W-1:0] BIN_START_RST = -24'sd200000;
    localparam logic [STEP_W-1:0]         BIN_STEP_RST  = 20'd100;
    localparam logic [BCNT_W-1:0]         BIN_COUNT_RST = 13'd3801;
    localparam logic [SLAB_W-1:0]         SLAB_RST      = 23'd5000;
    localparam logic signed [COORD_W-1:0] Z_LOW_RST     = 24'sd0;
    localparam logic signed [COORD_W-1:0] Z_HIGH_RST    = 24'sd700000;

    // Request codes.
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIN_START = 3'd0,
        CFG_BIN_STEP  = 3'd1,
        CFG_BIN_COUNT = 3'd2,
        CFG_SLAB      = 3'd3,
        CFG_Z_LOW     = 3'd4,
        CFG_Z_HIGH    = 3'd5
    } cfg_index_t;

    // One input item.
    typedef struct packed {
        logic                      req_type;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic [INDEX_W-1:0]        bin_index;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic signed [COORD_W-1:0] avg_y;
        logic signed [COORD_W-1:0] avg_z;
        logic [PCNT_W-1:0]         point_count;
        logic                      bin_empty;
    } out_item_t;

endpackage

`default_nettype wire

// ===== sv/point_section_bin_average.sv =====
// Section profile by binned neighborhood averaging.
//
// Input channel (in_valid, in_stall, in_item): an add item carries one point;
// if it passes the z window and slab test it is summed into up to three bins
// around its y position. A read item returns the mean y and z, the count and
// an empty flag of one bin on the output channel and clears that bin.
// Configuration writes (cfg_write, cfg_index, cfg_data) go straight into the registers.
//
// Timing: one shared restoring divider does one quotient bit per cycle over
// SUMW = 24 + COUNT_BITS bits. An add item divides once for the bin index and
// then does a read-modify-write per bin (read in ST_BRD, write in ST_BWR) on
// the bin memory, which has separate read and write ports. A read item divides
// twice, for the mean of y and then of z; an empty or out-of-range bin skips both.
// One item is in work at a time; in_stall is high while it runs.
//
// Reset loads the control registers, then a clearing pass writes zero to every
// bin with in_stall high. The result waits in an output register while
// out_stall is high; the block meanwhile takes a new item and only holds in its
// final step if a second result is ready before the first left.
`default_nettype none

module point_section_bin_average #(
    parameter int BINS       = psba_pkg::BINS_DEF,
    parameter int COUNT_BITS = psba_pkg::COUNT_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire psba_pkg::in_item_t               in_item,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output psba_pkg::out_item_t                   out_item,
    input  wire logic                             cfg_write,
    input  wire logic [psba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [psba_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import psba_pkg::*;

    localparam int AW      = $clog2(BINS);
    localparam int SUMW    = COORD_W + COUNT_BITS;
    localparam int ENTRY_W = 2 * SUMW + COUNT_BITS;
    localparam int DW      = SUMW;
    localparam int DVW     = (COUNT_BITS > STEP_W) ? COUNT_BITS : STEP_W;
    localparam int DCW     = $clog2(DW);
    localparam int QW      = COORD_W + 3;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_DIVQ  = 10'b0000000100,
        ST_BRD   = 10'b0000001000,
        ST_BWR   = 10'b0000010000,
        ST_RRD   = 10'b0000100000,
        ST_RLAT  = 10'b0001000000,
        ST_DIVY  = 10'b0010000000,
        ST_DIVZ  = 10'b0100000000,
        ST_PUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic signed [COORD_W-1:0] bin_start_reg, bin_start_next;
    logic [STEP_W-1:0]         bin_step_reg, bin_step_next;
    logic [BCNT_W-1:0]         bin_count_reg, bin_count_next;
    logic [SLAB_W-1:0]         slab_reg, slab_next;
    logic signed [COORD_W-1:0] z_low_reg, z_low_next;
    logic signed [COORD_W-1:0] z_high_reg, z_high_next;

    logic [DW-1:0]  dv_quo_reg, dv_quo_next;
    logic [DVW-1:0] dv_rem_reg, dv_rem_next;
    logic [DVW-1:0] dv_den_reg, dv_den_next;
    logic [DCW-1:0] dv_cnt_reg, dv_cnt_next;
    logic           neg_reg, neg_next;

    logic signed [QW-1:0]      q_reg, q_next;
    logic                      rzero_reg, rzero_next;
    logic [1:0]                j_reg, j_next;
    logic signed [COORD_W-1:0] py_reg, py_next;
    logic signed [COORD_W-1:0] pz_reg, pz_next;
    logic [INDEX_W-1:0]        idx_reg, idx_next;
    logic signed [SUMW-1:0]    sz_reg, sz_next;
    logic [COUNT_BITS-1:0]     cnt_reg, cnt_next;
    out_item_t                 res_reg, res_next;
    out_item_t                 out_reg, out_next;
    logic                      out_valid_reg, out_valid_next;

    // Bin memory: {sum of y, sum of z, count}.
    logic [ENTRY_W-1:0] mem [BINS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    logic [ENTRY_W-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Fields of the entry just read.
    logic signed [SUMW-1:0] rd_sy;
    logic signed [SUMW-1:0] rd_sz;
    logic [COUNT_BITS-1:0]  rd_cnt;
    assign rd_sy  = rd_data_reg[ENTRY_W-1 -: SUMW];
    assign rd_sz  = rd_data_reg[COUNT_BITS +: SUMW];
    assign rd_cnt = rd_data_reg[COUNT_BITS-1:0];

    // One restoring divider step.
    logic [DVW:0]   dv_trial;
    logic           dv_ge;
    logic [DVW-1:0] dv_rem_step;
    logic [DW-1:0]  dv_quo_step;
    logic           dv_last;
    logic [DW-1:0]  dv_signed_q;
    assign dv_trial    = {dv_rem_reg, dv_quo_reg[DW-1]};
    assign dv_ge       = dv_trial >= {1'b0, dv_den_reg};
    assign dv_rem_step = dv_ge ? DVW'(dv_trial - {1'b0, dv_den_reg}) : dv_trial[DVW-1:0];
    assign dv_quo_step = {dv_quo_reg[DW-2:0], dv_ge};
    assign dv_last     = (dv_cnt_reg == DCW'(DW - 1));
    assign dv_signed_q = neg_reg ? (-dv_quo_step) : dv_quo_step;

    // Point acceptance and offset from the first bin center.
    logic signed [COORD_W:0] ax;
    logic signed [COORD_W:0] dy;
    logic [COORD_W:0]        dy_mag;
    logic                    point_ok;
    assign ax = in_item.point_x[COORD_W-1] ? -{in_item.point_x[COORD_W-1], in_item.point_x}
                                           : {in_item.point_x[COORD_W-1], in_item.point_x};
    assign dy = {in_item.point_y[COORD_W-1], in_item.point_y}
              - {bin_start_reg[COORD_W-1], bin_start_reg};
    assign dy_mag = dy[COORD_W] ? (-dy) : dy;
    assign point_ok = (bin_step_reg != '0)
                   && (in_item.point_z >= z_low_reg) && (in_item.point_z <= z_high_reg)
                   && ($unsigned(ax) <= {2'b00, slab_reg});

    // Floor quotient from the final divider step.
    logic [QW-1:0] qm;
    logic          rnz;
    assign qm  = {1'b0, dv_quo_step[QW-2:0]};
    assign rnz = (dv_rem_step != '0);

    // Candidate bin and its range check.
    logic signed [QW-1:0] k_cur;
    logic [31:0]          lim;
    logic                 k_ok;
    assign k_cur = q_reg + QW'(j_reg) - QW'(1);
    assign lim   = (32'(bin_count_reg) < BINS) ? 32'(bin_count_reg) : BINS;
    assign k_ok  = ((j_reg != 2'd0) || rzero_reg) && !k_cur[QW-1] && (32'(k_cur) < lim);

    // Saturated count for the result.
    logic [31:0] cnt_wide;
    assign cnt_wide = 32'(cnt_reg);

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        bin_start_next = bin_start_reg;
        bin_step_next  = bin_step_reg;
        bin_count_next = bin_count_reg;
        slab_next      = slab_reg;
        z_low_next     = z_low_reg;
        z_high_next    = z_high_reg;
        dv_quo_next    = dv_quo_reg;
        dv_rem_next    = dv_rem_reg;
        dv_den_next    = dv_den_reg;
        dv_cnt_next    = dv_cnt_reg;
        neg_next       = neg_reg;
        q_next         = q_reg;
        rzero_next     = rzero_reg;
        j_next         = j_reg;
        py_next        = py_reg;
        pz_next        = pz_reg;
        idx_next       = idx_reg;
        sz_next        = sz_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_we         = 1'b0;
        mem_waddr      = AW'(k_cur);
        mem_raddr      = AW'(k_cur);
        mem_wdata      = '0;

        // Configuration writes.
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_BIN_START: bin_start_next = cfg_data[COORD_W-1:0];
                CFG_BIN_STEP:  bin_step_next  = cfg_data[STEP_W-1:0];
                CFG_BIN_COUNT: bin_count_next = cfg_data[BCNT_W-1:0];
                CFG_SLAB:      slab_next      = cfg_data[SLAB_W-1:0];
                CFG_Z_LOW:     z_low_next     = cfg_data[COORD_W-1:0];
                CFG_Z_HIGH:    z_high_next    = cfg_data[COORD_W-1:0];
                default:       ;
            endcase
        end

        // Divider steps in any dividing state.
        if ((state_reg == ST_DIVQ) || (state_reg == ST_DIVY) || (state_reg == ST_DIVZ))
        begin
            dv_quo_next = dv_quo_step;
            dv_rem_next = dv_rem_step;
            dv_cnt_next = dv_cnt_reg + DCW'(1);
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(BINS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_item.req_type == REQ_READ)
                    begin
                        idx_next   = in_item.bin_index;
                        state_next = ST_RRD;
                    end
                    else if (point_ok)
                    begin
                        py_next     = in_item.point_y;
                        pz_next     = in_item.point_z;
                        neg_next    = dy[COORD_W];
                        dv_quo_next = DW'(dy_mag);
                        dv_rem_next = '0;
                        dv_den_next = DVW'(bin_step_reg);
                        dv_cnt_next = '0;
                        state_next  = ST_DIVQ;
                    end
                end
            end
            ST_DIVQ:
            begin
                if (dv_last)
                begin
                    if (neg_reg)
                    begin
                        q_next = rnz ? (-$signed(qm) - QW'(1)) : -$signed(qm);
                    end
                    else
                    begin
                        q_next = $signed(qm);
                    end
                    rzero_next = !rnz;
                    j_next     = 2'd0;
                    state_next = ST_BRD;
                end
            end
            ST_BRD:
            begin
                // Read the candidate bin, or skip it.
                if (k_ok)
                begin
                    state_next = ST_BWR;
                end
                else
                begin
                    j_next     = j_reg + 2'd1;
                    state_next = (j_reg == 2'd2) ? ST_IDLE : ST_BRD;
                end
            end
            ST_BWR:
            begin
                // Add the point unless the bin count is saturated.
                if (rd_cnt != COUNT_MAX)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {rd_sy + SUMW'(py_reg), rd_sz + SUMW'(pz_reg),
                                 rd_cnt + COUNT_BITS'(1)};
                end
                j_next     = j_reg + 2'd1;
                state_next = (j_reg == 2'd2) ? ST_IDLE : ST_BRD;
            end
            ST_RRD:
            begin
                mem_raddr = AW'(idx_reg);
                if (32'(idx_reg) >= BINS)
                begin
                    res_next   = '{avg_y: '0, avg_z: '0, point_count: '0, bin_empty: 1'b1};
                    state_next = ST_PUT;
                end
                else
                begin
                    state_next = ST_RLAT;
                end
            end
            ST_RLAT:
            begin
                // Clear the bin and start on the mean of y.
                mem_we    = 1'b1;
                mem_waddr = AW'(idx_reg);
                mem_wdata = '0;
                if (rd_cnt == '0)
                begin
                    res_next   = '{avg_y: '0, avg_z: '0, point_count: '0, bin_empty: 1'b1};
                    state_next = ST_PUT;
                end
                else
                begin
                    sz_next     = rd_sz;
                    cnt_next    = rd_cnt;
                    neg_next    = rd_sy[SUMW-1];
                    dv_quo_next = rd_sy[SUMW-1] ? DW'(-rd_sy) : DW'(rd_sy);
                    dv_rem_next = '0;
                    dv_den_next = DVW'(rd_cnt);
                    dv_cnt_next = '0;
                    state_next  = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (dv_last)
                begin
                    res_next.avg_y = dv_signed_q[COORD_W-1:0];
                    neg_next       = sz_reg[SUMW-1];
                    dv_quo_next    = sz_reg[SUMW-1] ? DW'(-sz_reg) : DW'(sz_reg);
                    dv_rem_next    = '0;
                    dv_den_next    = DVW'(cnt_reg);
                    dv_cnt_next    = '0;
                    state_next     = ST_DIVZ;
                end
            end
            ST_DIVZ:
            begin
                if (dv_last)
                begin
                    res_next.avg_z       = dv_signed_q[COORD_W-1:0];
                    res_next.point_count = (cnt_wide > 32'd65535) ? '1 : cnt_wide[PCNT_W-1:0];
                    res_next.bin_empty   = 1'b0;
                    state_next           = ST_PUT;
                end
            end
            ST_PUT:
            begin
                // Hand the result to the output register once it is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            bin_start_reg <= BIN_START_RST;
            bin_step_reg  <= BIN_STEP_RST;
            bin_count_reg <= BIN_COUNT_RST;
            slab_reg      <= SLAB_RST;
            z_low_reg     <= Z_LOW_RST;
            z_high_reg    <= Z_HIGH_RST;
            dv_cnt_reg    <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            bin_start_reg <= bin_start_next;
            bin_step_reg  <= bin_step_next;
            bin_count_reg <= bin_count_next;
            slab_reg      <= slab_next;
            z_low_reg     <= z_low_next;
            z_high_reg    <= z_high_next;
            dv_cnt_reg    <= dv_cnt_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        dv_quo_reg <= dv_quo_next;
        dv_rem_reg <= dv_rem_next;
        dv_den_reg <= dv_den_next;
        neg_reg    <= neg_next;
        q_reg      <= q_next;
        rzero_reg  <= rzero_next;
        py_reg     <= py_next;
        pz_reg     <= pz_next;
        idx_reg    <= idx_next;
        sz_reg     <= sz_next;
        cnt_reg    <= cnt_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

`default_nettype wire

// ===== sv/psba_checker.sv =====
`default_nettype none

module psba_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire psba_pkg::in_item_t  in_item,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire psba_pkg::out_item_t out_item
);
    import psba_pkg::*;

    // A waiting result holds until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // An accepted read item keeps the block busy in the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_item.req_type == REQ_READ) |=> in_stall)
        else $error("read item accepted without the block going busy");

    // An empty bin reports all zero fields.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.bin_empty |->
            (out_item.avg_y == '0) && (out_item.avg_z == '0) && (out_item.point_count == '0))
        else $error("empty bin with nonzero fields");

    // A bin with points reports a nonzero count.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.bin_empty |-> out_item.point_count != '0)
        else $error("nonempty bin with zero count");

endmodule

bind point_section_bin_average psba_checker u_psba_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

`default_nettype wire
